@@ rtl/ipatf_pkg.sv @@
// Package for the IP address text formatter: codes, types and helper functions.
`timescale 1ns / 1ps

package ipatf_pkg;

    // Family codes on the input beat
    localparam logic [1:0] FAM_NONE = 2'd0;
    localparam logic [1:0] FAM_V4   = 2'd1;
    localparam logic [1:0] FAM_V6   = 2'd2;

    // Field widths
    localparam int FAMILY_W = 2;
    localparam int ADDR_W   = 64;
    localparam int CHAR_W   = 7;

    // ASCII codes
    localparam logic [6:0] CH_NUL   = 7'h00;
    localparam logic [6:0] CH_DOT   = 7'h2e;
    localparam logic [6:0] CH_COLON = 7'h3a;
    localparam logic [6:0] CH_ZERO  = 7'h30;
    localparam logic [6:0] CH_LOW_A = 7'h61;

    // Sub-steps inside one group: the last digit for IPv6 and IPv4, and the separator
    localparam logic [2:0] V6_LAST_SUB = 3'd4;
    localparam logic [2:0] V4_LAST_SUB = 3'd3;
    localparam logic [2:0] SUB_SEP     = 3'd0;

    // One address, taken apart and ready for the character walker
    typedef struct packed {
        logic [1:0]            fam;
        logic [7:0][15:0]      grp;     // IPv6 groups, group 0 first
        logic [7:0][2:0]       ndig;    // digits to print per group or byte
        logic [3:0][2:0][3:0]  dec;     // IPv4 bytes: [2] hundreds, [1] tens, [0] ones
        logic                  has_run; // a zero run of two or more is compressed
        logic [2:0]            run_s;   // first group of that run
        logic [3:0]            run_e;   // first group after that run (up to 8)
    } t_job;

    // Map a nibble to its lower-case hex character
    function automatic logic [6:0] hex_char(input logic [3:0] nib);
        if (nib < 4'd10) begin
            hex_char = CH_ZERO + {3'd0, nib};
        end else begin
            hex_char = CH_LOW_A + {3'd0, nib - 4'd10};
        end
    endfunction

    // Split a byte into hundreds, tens and ones
    function automatic logic [11:0] dec_digits(input logic [7:0] v);
        logic [1:0]  h;
        logic [6:0]  r;
        logic [14:0] prod;
        logic [3:0]  t;
        logic [6:0]  o;
        if (v >= 8'd200) begin
            h = 2'd2;
        end else if (v >= 8'd100) begin
            h = 2'd1;
        end else begin
            h = 2'd0;
        end
        r    = 7'(v - 8'(h) * 8'd100);
        // divide by ten through a reciprocal, exact for values below one hundred
        prod = 15'({8'd0, r} * 15'd205);
        t    = prod[14:11];
        o    = r - 7'(t) * 7'd10;
        dec_digits = {2'b00, h, t, o[3:0]};
    endfunction

    // Count the decimal digits of a byte split by dec_digits
    function automatic logic [2:0] dec_count(input logic [11:0] d);
        if (d[11:8] != 4'd0) begin
            dec_count = 3'd3;
        end else if (d[7:4] != 4'd0) begin
            dec_count = 3'd2;
        end else begin
            dec_count = 3'd1;
        end
    endfunction

    // Count the hex digits of a group without leading zeros
    function automatic logic [2:0] hex_count(input logic [15:0] g);
        if (g[15:12] != 4'd0) begin
            hex_count = 3'd4;
        end else if (g[11:8] != 4'd0) begin
            hex_count = 3'd3;
        end else if (g[7:4] != 4'd0) begin
            hex_count = 3'd2;
        end else begin
            hex_count = 3'd1;
        end
    endfunction

    // First sub-step of group or byte j: separator or its leading digit
    function automatic logic [2:0] start_sub(input t_job job, input logic [2:0] j);
        if (job.fam == FAM_V6) begin
            if (job.has_run && j == job.run_s) begin
                start_sub = SUB_SEP;
            end else if (j != 3'd0 && !(job.has_run && {1'b0, j} == job.run_e)) begin
                start_sub = SUB_SEP;
            end else begin
                start_sub = V6_LAST_SUB + 3'd1 - job.ndig[j];
            end
        end else begin
            if (j != 3'd0) begin
                start_sub = SUB_SEP;
            end else begin
                start_sub = V4_LAST_SUB + 3'd1 - job.ndig[j];
            end
        end
    endfunction

endpackage

@@ rtl/ipatf_in_if.sv @@
// Channel interfaces: address beats in, text character beats out.
`timescale 1ns / 1ps

interface ipatf_in_if import ipatf_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [FAMILY_W-1:0] family;
    logic [ADDR_W-1:0]   addr_upper;
    logic [ADDR_W-1:0]   addr_lower;

    modport source (output valid, output family, output addr_upper, output addr_lower,
                    input ready);
    modport sink   (input valid, input family, input addr_upper, input addr_lower,
                    output ready);
endinterface

interface ipatf_out_if import ipatf_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] text_char;
    logic              empty_text;
    logic              last_char;

    modport source (output valid, output text_char, output empty_text, output last_char,
                    input ready);
    modport sink   (input valid, input text_char, input empty_text, input last_char,
                    output ready);
endinterface

@@ rtl/ip_address_text_formatter_core.sv @@
// Top level of the IP address text formatter: address in, ASCII text out.
`timescale 1ns / 1ps

// Takes one address beat (family, 128-bit address) and sends its text one ASCII
// character per output beat, with last_char on the final one. IPv4 gives a dotted
// decimal quad (7 to 15 beats), IPv6 gives lower-case hex groups with the longest
// zero run shown as "::" (2 to 39 beats), and no family gives a single beat with
// empty_text set. The output runs at one character per cycle while o_text.ready
// does not hold it back; that single character walker sets the rate. A taken
// address beat is stored in r_job, and its first character then passes into the
// output register. The next address is taken in the cycle its predecessor's last
// character moves into the output register, so texts follow with no gap.
module ip_address_text_formatter_core
    import ipatf_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    ipatf_in_if.sink    i_addr,
    ipatf_out_if.source o_text
);

    t_job       n_job;
    t_job       r_job;
    logic       r_job_valid;
    logic [2:0] r_pos;
    logic [2:0] r_sub;
    logic [2:0] n_pos;
    logic [2:0] n_sub;

    logic [6:0] c_char;
    logic       c_empty;
    logic       c_last;
    logic       in_fire;
    logic       advance;

    logic       r_out_valid;
    logic [6:0] r_out_char;
    logic       r_out_empty;
    logic       r_out_last;

    // Take the address apart: groups, digit counts, zero run
    always_comb begin
        logic [7:0]      zero;
        logic [7:0][3:0] run_len;
        logic [3:0]      best_len;
        logic [2:0]      best_s;
        logic [11:0]     d;
        d         = '0;
        n_job.fam = i_addr.family;
        for (int i = 0; i < 4; i++) begin
            n_job.grp[i]     = i_addr.addr_upper[63-16*i -: 16];
            n_job.grp[i + 4] = i_addr.addr_lower[63-16*i -: 16];
        end
        for (int i = 0; i < 8; i++) begin
            zero[i] = (n_job.grp[i] == 16'd0);
        end
        // length of the zero run that starts at each group
        run_len[7] = zero[7] ? 4'd1 : 4'd0;
        for (int i = 6; i >= 0; i--) begin
            run_len[i] = zero[i] ? run_len[i + 1] + 4'd1 : 4'd0;
        end
        // keep the longest, leftmost on a tie
        best_len = 4'd0;
        best_s   = 3'd0;
        for (int i = 0; i < 8; i++) begin
            if (run_len[i] > best_len) begin
                best_len = run_len[i];
                best_s   = 3'(i);
            end
        end
        n_job.has_run = (best_len >= 4'd2);
        n_job.run_s   = best_s;
        n_job.run_e   = {1'b0, best_s} + best_len;
        n_job.dec     = '0;
        for (int i = 0; i < 8; i++) begin
            n_job.ndig[i] = hex_count(n_job.grp[i]);
        end
        if (i_addr.family == FAM_V4) begin
            for (int i = 0; i < 4; i++) begin
                d             = dec_digits(i_addr.addr_upper[63-8*i -: 8]);
                n_job.dec[i]  = d;
                n_job.ndig[i] = dec_count(d);
            end
        end
    end

    // Walk the text: pick this cycle's character and the next cursor
    always_comb begin
        logic [15:0] g;
        logic [3:0]  nib;
        logic [3:0]  digit;
        c_char  = CH_NUL;
        c_empty = 1'b0;
        c_last  = 1'b0;
        n_pos   = r_pos;
        n_sub   = r_sub;
        g       = r_job.grp[r_pos];
        case (r_sub)
            3'd1:    nib = g[15:12];
            3'd2:    nib = g[11:8];
            3'd3:    nib = g[7:4];
            default: nib = g[3:0];
        endcase
        case (r_sub)
            3'd1:    digit = r_job.dec[r_pos[1:0]][2];
            3'd2:    digit = r_job.dec[r_pos[1:0]][1];
            default: digit = r_job.dec[r_pos[1:0]][0];
        endcase
        case (r_job.fam)
            FAM_V6: begin
                if (r_job.has_run && r_pos == r_job.run_s) begin
                    c_char = CH_COLON;
                    if (r_sub == SUB_SEP) begin
                        n_sub = 3'd1;
                    end else begin
                        n_pos  = r_job.run_e[2:0];
                        n_sub  = start_sub(r_job, r_job.run_e[2:0]);
                        c_last = r_job.run_e[3];
                    end
                end else if (r_sub == SUB_SEP) begin
                    c_char = CH_COLON;
                    n_sub  = V6_LAST_SUB + 3'd1 - r_job.ndig[r_pos];
                end else begin
                    c_char = hex_char(nib);
                    if (r_sub == V6_LAST_SUB) begin
                        n_pos  = r_pos + 3'd1;
                        n_sub  = start_sub(r_job, r_pos + 3'd1);
                        c_last = (r_pos == 3'd7);
                    end else begin
                        n_sub = r_sub + 3'd1;
                    end
                end
            end
            FAM_V4: begin
                if (r_sub == SUB_SEP) begin
                    c_char = CH_DOT;
                    n_sub  = V4_LAST_SUB + 3'd1 - r_job.ndig[r_pos];
                end else begin
                    c_char = CH_ZERO + {3'd0, digit};
                    if (r_sub == V4_LAST_SUB) begin
                        n_pos  = r_pos + 3'd1;
                        n_sub  = start_sub(r_job, r_pos + 3'd1);
                        c_last = (r_pos == 3'd3);
                    end else begin
                        n_sub = r_sub + 3'd1;
                    end
                end
            end
            default: begin
                // no family, or the unused code: one empty beat
                c_char  = CH_NUL;
                c_empty = 1'b1;
                c_last  = 1'b1;
            end
        endcase
    end

    // Handshakes: advance when the output register is free or being drained
    assign advance      = r_job_valid && (!r_out_valid || o_text.ready);
    assign i_addr.ready = !r_job_valid || (advance && c_last);
    assign in_fire      = i_addr.valid && i_addr.ready;

    // Hold the current address and its cursor
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_job_valid <= 1'b0;
            r_pos       <= 3'd0;
            r_sub       <= 3'd0;
        end else begin
            if (in_fire) begin
                r_job_valid <= 1'b1;
                r_pos       <= 3'd0;
                r_sub       <= start_sub(n_job, 3'd0);
            end else if (advance) begin
                r_job_valid <= !c_last;
                r_pos       <= n_pos;
                r_sub       <= n_sub;
            end
        end
    end

    // Load the payload of a new address
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_job <= n_job;
        end
    end

    // Output register: valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (o_text.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output register: beat payload
    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_char  <= c_char;
            r_out_empty <= c_empty;
            r_out_last  <= c_last;
        end
    end

    assign o_text.valid      = r_out_valid;
    assign o_text.text_char  = r_out_char;
    assign o_text.empty_text = r_out_empty;
    assign o_text.last_char  = r_out_last;

endmodule
